/* rtl/fpba_pkg.sv */
// Shared types and codes for the fit-policy block allocator.
// No dependencies; imported by fpba_cell and fit_policy_block_allocator_core.
package fpba_pkg;

  // Operation field codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Placement rule codes; the unused code behaves as first fit.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

  // Control part of the search token that walks the cell row.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

/* rtl/fit_policy_block_allocator_core.sv */
// Top level of the fit-policy block allocator: handshake control, config
// registers and the row of fpba_cell instances. Depends on fpba_pkg.
// Loads give no result; a load whose block index is in range is written into the table as it is taken.
// A request sends a search token through the cell row one cell per cycle; the token
// leaving the row is captured, then the table update and the result register are
// loaded together once the output can take the result. No new item is taken meanwhile.
// Reset clears control, output valid and config (fit_policy 0, block_count 16);
// the size table is undefined until loaded.
module fit_policy_block_allocator_core #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  block_index,
  input  logic [15:0] size_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [3:0]  chosen_block,
  output logic [15:0] left_after
);
  import fpba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [1:0] fit_policy;
  logic [4:0] block_count;

  state_t state;
  state_t state_next;

  tok_ctl_t             ctl_chain  [NUM_BLOCKS+1];
  logic [IDX_W-1:0]     pick_chain [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] best_chain [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] req_chain  [NUM_BLOCKS+1];

  logic [SIZE_BITS+15:0] size_ext;
  logic [SIZE_BITS-1:0]  size_trunc;
  logic [IDX_W+3:0]      load_ext;
  logic                  load_ok;

  logic                 pend_found;
  logic [IDX_W-1:0]     pend_pick;
  logic [SIZE_BITS-1:0] pend_left;
  logic [IDX_W+3:0]     pick_ext;
  logic [SIZE_BITS+15:0] left_ext;

  logic                 in_xfer;
  logic                 out_free;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [SIZE_BITS-1:0] wr_data;

  always_comb begin
    size_ext   = {{SIZE_BITS{1'b0}}, size_value};
    size_trunc = size_ext[SIZE_BITS-1:0];
    load_ext   = {{IDX_W{1'b0}}, block_index};
    load_ok    = ({28'b0, block_index} < 32'(NUM_BLOCKS));
    pick_ext   = {4'b0, pend_pick};
    left_ext   = {16'b0, pend_left};
    out_free   = !out_valid || out_ready;
    in_xfer    = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= FIT_FIRST;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:  fit_policy  <= cfg_data[1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = load_ext[IDX_W-1:0];
    wr_data    = size_trunc;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (operation == OP_LOAD) begin
            wr_en = load_ok;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ctl_chain[NUM_BLOCKS].valid) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // Hold the update until the output register can take the result.
        if (out_free) begin
          wr_en      = pend_found;
          wr_idx     = pend_pick;
          wr_data    = pend_left;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Inject a fresh token into the head of the row on a request transfer.
  always_comb begin
    ctl_chain[0].valid = in_xfer && (operation == OP_REQUEST);
    ctl_chain[0].found = 1'b0;
    pick_chain[0]      = '0;
    best_chain[0]      = '0;
    req_chain[0]       = size_trunc;
  end

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    fpba_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .fit_policy  (fit_policy),
      .block_count (block_count),
      .prev_ctl    (ctl_chain[i]),
      .prev_pick   (pick_chain[i]),
      .prev_best   (best_chain[i]),
      .prev_req    (req_chain[i]),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .tok_ctl     (ctl_chain[i+1]),
      .tok_pick    (pick_chain[i+1]),
      .tok_best    (best_chain[i+1]),
      .tok_req     (req_chain[i+1])
    );
  end

  // Capture the token leaving the row; the chosen block holds at least the request.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && ctl_chain[NUM_BLOCKS].valid) begin
      pend_found <= ctl_chain[NUM_BLOCKS].found;
      pend_pick  <= ctl_chain[NUM_BLOCKS].found ? pick_chain[NUM_BLOCKS] : '0;
      pend_left  <= ctl_chain[NUM_BLOCKS].found ?
                    best_chain[NUM_BLOCKS] - req_chain[NUM_BLOCKS] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      granted      <= pend_found;
      chosen_block <= pick_ext[3:0];
      left_after   <= left_ext[15:0];
    end
  end

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    ctl_chain[NUM_BLOCKS].valid |-> state == ST_SCAN)
    else $error("token left the cell row outside a scan");

  a_head_idle: assert property (@(posedge clk) disable iff (rst)
    ctl_chain[0].valid |-> state == ST_IDLE && !ctl_chain[NUM_BLOCKS].valid)
    else $error("token injected while a search is in flight");

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_WRITE)
    else $error("result appeared without a finished search");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> chosen_block == 4'd0 && left_after == 16'd0)
    else $error("refused request carries a block or size");

  a_grant_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE && wr_en |-> pend_found && wr_idx == pend_pick)
    else $error("table update without a grant");

endmodule

/* rtl/fpba_cell.sv */
// One cell of the allocator row: holds one block's free size and refines the
// search token passing through it. Depends on fpba_pkg.
module fpba_cell #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           fit_policy,
  input  logic [4:0]           block_count,
  input  fpba_pkg::tok_ctl_t   prev_ctl,
  input  logic [IDX_W-1:0]     prev_pick,
  input  logic [SIZE_BITS-1:0] prev_best,
  input  logic [SIZE_BITS-1:0] prev_req,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [SIZE_BITS-1:0] wr_data,
  output fpba_pkg::tok_ctl_t   tok_ctl,
  output logic [IDX_W-1:0]     tok_pick,
  output logic [SIZE_BITS-1:0] tok_best,
  output logic [SIZE_BITS-1:0] tok_req
);
  import fpba_pkg::*;

  localparam logic [31:0]      CELL_POS = 32'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] free_size;
  logic                 active;
  logic                 fits;
  logic                 take;

  always_comb begin
    active = ({27'b0, block_count} > CELL_POS);
    fits   = active && (free_size >= prev_req);
    take   = fits && (!prev_ctl.found ||
                      (fit_policy == FIT_BEST  && free_size < prev_best) ||
                      (fit_policy == FIT_WORST && free_size > prev_best));
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == MY_IDX) begin
      free_size <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_ctl <= '0;
    end else begin
      tok_ctl.valid <= prev_ctl.valid;
      tok_ctl.found <= prev_ctl.found | fits;
    end
  end

  // Token payload: take over this block when it beats the running choice.
  always_ff @(posedge clk) begin
    tok_pick <= take ? MY_IDX : prev_pick;
    tok_best <= take ? free_size : prev_best;
    tok_req  <= prev_req;
  end

endmodule
